[design/eco_pkg.sv]
// Package for the Euler camera orientation block: widths, constants, CORDIC table.
// Used by every module in design/.
package eco_pkg;

    localparam int ANG_W        = 25;
    localparam int CUR_W        = 16;
    localparam int SENS_W       = 16;
    localparam int VEC_W        = 16;
    localparam int WORK_W       = 34;
    localparam int WORK_FRAC    = 30;
    localparam int VEC_FRAC_DEF = 15;
    localparam int STEPS_DEF    = 16;
    localparam int ATAN_LEN     = 30;
    localparam int ZW           = 27;

    localparam logic signed [ZW-1:0] ANG_HALF    = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] ANG_QUARTER = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] PITCH_LIM   = ZW'(89 * 65536);
    localparam logic signed [WORK_W-1:0] CORDIC_X0 = WORK_W'(652032874);
    localparam logic signed [WORK_W-1:0] WORK_ONE  = WORK_W'(64'sd1 <<< WORK_FRAC);

    // register indexes on the configuration port
    localparam logic [1:0] REG_SENS  = 2'd0;
    localparam logic [1:0] REG_LIMEN = 2'd1;
    localparam logic [1:0] REG_SYAW  = 2'd2;
    localparam logic [1:0] REG_SPIT  = 2'd3;

    // data handed from cell to cell
    typedef struct packed {
        logic signed [WORK_W-1:0] x;
        logic signed [WORK_W-1:0] y;
        logic signed [ZW-1:0]     z;
    } cordic_t;

    function automatic logic signed [ZW-1:0] atan_val(input int i);
        case (i)
            0: atan_val = ZW'(2949120);   1: atan_val = ZW'(1740967);
            2: atan_val = ZW'(919879);    3: atan_val = ZW'(466945);
            4: atan_val = ZW'(234379);    5: atan_val = ZW'(117304);
            6: atan_val = ZW'(58666);     7: atan_val = ZW'(29335);
            8: atan_val = ZW'(14668);     9: atan_val = ZW'(7334);
            10: atan_val = ZW'(3667);     11: atan_val = ZW'(1833);
            12: atan_val = ZW'(917);      13: atan_val = ZW'(458);
            14: atan_val = ZW'(229);      15: atan_val = ZW'(115);
            16: atan_val = ZW'(57);       17: atan_val = ZW'(29);
            18: atan_val = ZW'(14);       19: atan_val = ZW'(7);
            20: atan_val = ZW'(4);        21: atan_val = ZW'(2);
            22: atan_val = ZW'(1);
            default: atan_val = '0;
        endcase
    endfunction

endpackage

[design/eco_cell.sv]
// One CORDIC rotation cell with a register on its output.
// Depends on eco_pkg.
module eco_cell import eco_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic    aclk,
    input  cordic_t d_in,
    output cordic_t d_out
);
    localparam logic signed [ZW-1:0] ATAN = atan_val(STEP);
    localparam int SH = (STEP < WORK_W) ? STEP : WORK_W - 1;

    cordic_t d_reg, d_next;
    logic signed [WORK_W-1:0] xs, ys;

    // rotate toward zero residual angle
    always_comb begin
        xs = d_in.x >>> SH;
        ys = d_in.y >>> SH;
        d_next = d_in;
        if (STEP < ATAN_LEN) begin
            if (!d_in.z[ZW-1]) begin
                d_next.x = d_in.x - ys;
                d_next.y = d_in.y + xs;
                d_next.z = d_in.z - ATAN;
            end else begin
                d_next.x = d_in.x + ys;
                d_next.y = d_in.y - xs;
                d_next.z = d_in.z + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        d_reg <= d_next;
    end

    assign d_out = d_reg;
endmodule

[design/eco_chain.sv]
// Row of CORDIC cells: sine and cosine of one angle, one step per cell.
// Depends on eco_pkg and eco_cell.
module eco_chain import eco_pkg::*; #(
    parameter int CORDIC_STEPS = STEPS_DEF
) (
    input  logic                     aclk,
    input  logic signed [ZW-1:0]     angle,
    input  logic                     negate,
    output logic signed [WORK_W-1:0] cos_out,
    output logic signed [WORK_W-1:0] sin_out
);
    cordic_t link [CORDIC_STEPS+1];
    logic    neg_pipe [CORDIC_STEPS+1];

    assign link[0] = '{x: CORDIC_X0, y: '0, z: angle};
    assign neg_pipe[0] = negate;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        eco_cell #(.STEP(i)) u_cell (.aclk(aclk), .d_in(link[i]), .d_out(link[i+1]));
        always_ff @(posedge aclk) begin
            neg_pipe[i+1] <= neg_pipe[i];
        end
    end

    // fold the half turn back in
    assign cos_out = neg_pipe[CORDIC_STEPS] ? -link[CORDIC_STEPS].x : link[CORDIC_STEPS].x;
    assign sin_out = neg_pipe[CORDIC_STEPS] ? -link[CORDIC_STEPS].y : link[CORDIC_STEPS].y;
endmodule

[design/euler_camera_orientation.sv]
// Top level of the Euler camera orientation block: angle update, CORDIC
// chain, vector assembly. Depends on eco_pkg, eco_chain.
//
//  channel  | dir | payload
//  s_axis   | in  | tdata: cursor_x[15:0], cursor_y[31:16]
//  m_axis   | out | tdata: yaw, pitch, front, right, up (see port); tuser: degenerate
//  cfg      | in  | cfg_index (0 sens, 1 limit enable, 2 start yaw, 3 start pitch)
//
// One beat at a time: sum the moves at accept, wrap or clamp the angles,
// feed yaw then pitch into the CORDIC row, pitch in the cycle after yaw,
// multiply and round, then the result waits in the output register. No
// new beat is taken until the result has left the output register.
// Reset is synchronous, active low; a stalled result holds s_tready low.
module euler_camera_orientation import eco_pkg::*; #(
    parameter int VEC_FRAC_BITS = VEC_FRAC_DEF,
    parameter int CORDIC_STEPS  = STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // cursor_x, cursor_y
    output logic         m_tvalid,
    input  logic         m_tready,
    // yaw_angle[24:0], pitch_angle[49:25], front_x/y/z, right_x/y/z, up_x/y/z
    // at 50+16k, zero fill to 200
    output logic [199:0] m_tdata,
    output logic         m_tuser,   // degenerate
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001, ST_YAW = 5'b00010, ST_WAIT = 5'b00100,
        ST_MUL  = 5'b01000, ST_OUT = 5'b10000
    } state_t;

    localparam int LAT = CORDIC_STEPS;
    localparam int CW  = $clog2(LAT + 5);
    localparam int SH  = WORK_FRAC - VEC_FRAC_BITS;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg;

    logic [SENS_W-1:0]      sens_reg;
    logic                   limen_reg;
    logic signed [ANG_W-1:0] syaw_reg, spit_reg;
    logic                   seen_reg;
    logic signed [CUR_W-1:0] px_reg, py_reg;
    logic signed [ANG_W-1:0] yaw_reg, pitch_reg;
    logic signed [34:0]      yaw_sum_reg, pit_sum_reg;
    logic signed [VEC_W-1:0] hr_reg [3], hu_reg [3];

    logic signed [WORK_W-1:0] cyw_reg, syw_reg, cp_reg, sp_reg;
    logic signed [WORK_W-1:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic degen_reg, sgn_reg;
    logic signed [VEC_W-1:0] vec_reg [9];

    logic accept;
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg  <= SENS_W'(6554);
            limen_reg <= 1'b1;
            syaw_reg  <= ANG_W'(-5898240);
            spit_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SENS:  sens_reg  <= cfg_data[SENS_W-1:0];
                REG_LIMEN: limen_reg <= cfg_data[0];
                REG_SYAW:  syaw_reg  <= cfg_data[ANG_W-1:0];
                REG_SPIT:  spit_reg  <= cfg_data[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    // angle update
    logic signed [CUR_W-1:0] cx, cy;
    logic signed [ANG_W-1:0] by, bp;
    logic signed [CUR_W-1:0] bx0, by0;
    logic signed [CUR_W:0]   dx, dy;
    logic signed [34:0]      ny, np;
    logic signed [ANG_W-1:0] yaw_new, pit_new;

    // full turn is 45 * 2^19: split off the low 19 bits, reduce the rest
    // modulo 45 by a reciprocal multiply
    function automatic logic signed [ANG_W-1:0] wrap(input logic signed [34:0] v);
        logic signed [35:0] u;
        logic signed [16:0] hi;
        logic [16:0]        n;
        logic [33:0]        prod;
        logic [12:0]        q;
        logic [5:0]         rem;
        logic [24:0]        r;
        u    = 36'(v) + 36'(ANG_HALF);
        hi   = u[35:19];
        n    = 17'(hi + 17'sd32805);
        prod = {17'b0, n} * 34'd46604;
        q    = prod[33:21];
        rem  = 6'(n - {4'b0, q} * 17'd45);
        r    = {rem, u[18:0]};
        return ANG_W'($signed(r) - ANG_W'(ANG_HALF));
    endfunction

    always_comb begin
        cx  = s_tdata[15:0];
        cy  = s_tdata[31:16];
        by  = seen_reg ? yaw_reg : syaw_reg;
        bp  = seen_reg ? pitch_reg : spit_reg;
        bx0 = seen_reg ? px_reg : cx;
        by0 = seen_reg ? py_reg : cy;
        dx  = {cx[CUR_W-1], cx} - {bx0[CUR_W-1], bx0};
        dy  = {by0[CUR_W-1], by0} - {cy[CUR_W-1], cy};
        ny  = 35'(by) + 35'(dx) * 35'($signed({1'b0, sens_reg}));
        np  = 35'(bp) + 35'(dy) * 35'($signed({1'b0, sens_reg}));
        yaw_new = wrap(yaw_sum_reg);
        if (limen_reg) begin
            if (pit_sum_reg > 35'(PITCH_LIM)) pit_new = ANG_W'(PITCH_LIM);
            else if (pit_sum_reg < -35'(PITCH_LIM)) pit_new = ANG_W'(-PITCH_LIM);
            else pit_new = pit_sum_reg[ANG_W-1:0];
        end else begin
            pit_new = wrap(pit_sum_reg);
        end
    end

    // chain feed: yaw at count 1, pitch at count 2
    logic signed [ZW-1:0] ang_in, ang_red;
    logic neg_in;
    always_comb begin
        ang_in = (cnt_reg == CW'(1)) ? ZW'(yaw_reg) : ZW'(pitch_reg);
        neg_in = 1'b0;
        ang_red = ang_in;
        if (ang_in > ANG_QUARTER) begin
            ang_red = ang_in - ANG_HALF; neg_in = 1'b1;
        end else if (ang_in < -ANG_QUARTER) begin
            ang_red = ang_in + ANG_HALF; neg_in = 1'b1;
        end
    end

    logic signed [WORK_W-1:0] c_out, s_out;
    eco_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_chain (
        .aclk(aclk), .angle(ang_red), .negate(neg_in), .cos_out(c_out), .sin_out(s_out)
    );

    function automatic logic signed [WORK_W-1:0] mulw(input logic signed [WORK_W-1:0] a,
                                                      input logic signed [WORK_W-1:0] b);
        logic signed [2*WORK_W-1:0] p;
        p = a * b + (2*WORK_W)'(64'sd1 <<< (WORK_FRAC - 1));
        return WORK_W'(p >>> WORK_FRAC);
    endfunction

    function automatic logic signed [VEC_W-1:0] tovec(input logic signed [WORK_W-1:0] v);
        logic signed [WORK_W:0] r;
        r = ((WORK_W+1)'(v) + (WORK_W+1)'((64'sd1 <<< SH) >>> 1)) >>> SH;
        if (r > (WORK_W+1)'((64'sd1 <<< VEC_FRAC_BITS) - 1))
            r = (WORK_W+1)'((64'sd1 <<< VEC_FRAC_BITS) - 1);
        if (r < -(WORK_W+1)'(64'sd1 <<< VEC_FRAC_BITS))
            r = -(WORK_W+1)'(64'sd1 <<< VEC_FRAC_BITS);
        return r[VEC_W-1:0];
    endfunction

    logic degen_now;
    assign degen_now = (ZW'(pitch_reg) == ANG_QUARTER) || (ZW'(pitch_reg) == -ANG_QUARTER);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_YAW;
            ST_YAW:  state_next = ST_WAIT;
            ST_WAIT: if (cnt_reg == CW'(LAT + 1)) state_next = ST_MUL;
            ST_MUL:  if (cnt_reg == CW'(LAT + 4)) state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            seen_reg    <= 1'b0;
            px_reg      <= '0;
            py_reg      <= '0;
            yaw_reg     <= '0;
            pitch_reg   <= '0;
            yaw_sum_reg <= '0;
            pit_sum_reg <= '0;
            for (int k = 0; k < 3; k++) begin
                hr_reg[k] <= '0;
                hu_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_reg == ST_IDLE) ? '0 : cnt_reg + 1'b1;
            if (accept) begin
                seen_reg    <= 1'b1;
                px_reg      <= cx;
                py_reg      <= cy;
                yaw_sum_reg <= ny;
                pit_sum_reg <= np;
            end
            // wrap or clamp the summed angles
            if (state_reg == ST_YAW) begin
                yaw_reg   <= yaw_new;
                pitch_reg <= pit_new;
            end
            // latch right and up when the vectors are final, unless the pitch is degenerate
            if (state_reg == ST_MUL && cnt_reg == CW'(LAT + 4) && !degen_reg) begin
                hr_reg[0] <= tovec(sgn_reg ? syw_reg : -syw_reg);
                hr_reg[1] <= tovec(sgn_reg ? -cyw_reg : cyw_reg);
                hr_reg[2] <= '0;
                hu_reg[0] <= tovec(sgn_reg ? -m2_reg : m2_reg);
                hu_reg[1] <= tovec(sgn_reg ? -m3_reg : m3_reg);
                hu_reg[2] <= tovec(sgn_reg ? cp_reg : -cp_reg);
            end
        end
    end

    // capture chain outputs and products
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WAIT && cnt_reg == CW'(LAT + 1)) begin
            cyw_reg <= c_out;
            syw_reg <= s_out;
        end
        if (state_reg == ST_MUL && cnt_reg == CW'(LAT + 2)) begin
            degen_reg <= degen_now;
            sgn_reg   <= (ZW'(pitch_reg) > ANG_QUARTER) || (ZW'(pitch_reg) < -ANG_QUARTER);
            cp_reg    <= degen_now ? '0 : c_out;
            sp_reg    <= degen_now ? (pitch_reg[ANG_W-1] ? -WORK_ONE : WORK_ONE) : s_out;
        end
        if (state_reg == ST_MUL && cnt_reg == CW'(LAT + 4)) begin
            vec_reg[0] <= tovec(m0_reg);
            vec_reg[1] <= tovec(m1_reg);
            vec_reg[2] <= tovec(sp_reg);
        end
    end

    // one multiply per product, registered
    always_ff @(posedge aclk) begin
        m0_reg <= mulw(cyw_reg, cp_reg);
        m1_reg <= mulw(syw_reg, cp_reg);
        m2_reg <= mulw(cyw_reg, sp_reg);
        m3_reg <= mulw(syw_reg, sp_reg);
    end

    // output register view
    always_comb begin
        m_tdata = '0;
        m_tdata[24:0]  = yaw_reg;
        m_tdata[49:25] = pitch_reg;
        m_tdata[65:50] = vec_reg[0];
        m_tdata[81:66] = vec_reg[1];
        m_tdata[97:82] = vec_reg[2];
        m_tdata[113:98]  = hr_reg[0];
        m_tdata[129:114] = hr_reg[1];
        m_tdata[145:130] = hr_reg[2];
        m_tdata[161:146] = hu_reg[0];
        m_tdata[177:162] = hu_reg[1];
        m_tdata[193:178] = hu_reg[2];
    end
    assign m_tuser  = degen_reg;
    assign m_tvalid = (state_reg == ST_OUT);
endmodule
